// File: sv/gbs_pkg.sv
`timescale 1ns / 1ps
package gbs_pkg;

   // Default for the top-level parameter
   localparam int MAX_KEPT_DEFAULT = 128;

   // Coordinate width: corners are signed, sizes one bit narrower and unsigned
   localparam int COORD_BITS = 16;

   // Fixed field widths
   localparam int THR_BITS   = 16;
   localparam int IDX_BITS   = 16;
   localparam int CLASS_BITS = 8;

   // Configuration port
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 16;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IOU_THRESHOLD  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CLASS_AGNOSTIC = 1'b1;

   localparam logic [THR_BITS-1:0] IOU_THRESHOLD_RESET  = 16'd29491;
   localparam logic                CLASS_AGNOSTIC_RESET = 1'b0;

   localparam logic [IDX_BITS-1:0] IDX_MAX = '1;

   // Input box
   typedef struct packed {
      logic signed [COORD_BITS-1:0] box_x;
      logic signed [COORD_BITS-1:0] box_y;
      logic [COORD_BITS-2:0]        box_w;
      logic [COORD_BITS-2:0]        box_h;
      logic [CLASS_BITS-1:0]        class_label;
      logic                         first_of_frame;
   } req_type;

   // Result
   typedef struct packed {
      logic                keep;
      logic [IDX_BITS-1:0] input_index;
      logic                list_full;
   } rsp_type;

   // Status from the overlap unit to the sequencer
   typedef struct packed {
      logic busy;
      logic hit;
   } unit_status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PREP,
      S_SCAN,
      S_DRAIN,
      S_FINISH
   } state_type;

endpackage

// File: sv/gbs_store.sv
`timescale 1ns / 1ps
module gbs_store #(
   parameter int MAX_KEPT   = gbs_pkg::MAX_KEPT_DEFAULT,
   parameter int COORD_BITS = gbs_pkg::COORD_BITS,
   localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1,
   localparam int CB = COORD_BITS,
   localparam int WB = COORD_BITS - 1,
   localparam int AB = 2 * (COORD_BITS - 1)
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [AW-1:0]                   wr_addr,
   input  logic signed [CB-1:0]            wr_x,
   input  logic signed [CB-1:0]            wr_y,
   input  logic [WB-1:0]                   wr_w,
   input  logic [WB-1:0]                   wr_h,
   input  logic [gbs_pkg::CLASS_BITS-1:0]  wr_cls,
   input  logic [AB-1:0]                   wr_area,
   input  logic [AW-1:0]                   rd_addr,
   output logic signed [CB-1:0]            rd_x,
   output logic signed [CB-1:0]            rd_y,
   output logic [WB-1:0]                   rd_w,
   output logic [WB-1:0]                   rd_h,
   output logic [gbs_pkg::CLASS_BITS-1:0]  rd_cls,
   output logic [AB-1:0]                   rd_area
);
   import gbs_pkg::*;

   // Entry layout, low to high: area, class, h, w, y, x
   localparam int AREA_LO = 0;
   localparam int CLS_LO  = AREA_LO + AB;
   localparam int H_LO    = CLS_LO + CLASS_BITS;
   localparam int W_LO    = H_LO + WB;
   localparam int Y_LO    = W_LO + WB;
   localparam int X_LO    = Y_LO + CB;
   localparam int DW      = X_LO + CB;

   logic [DW-1:0] mem [MAX_KEPT];
   logic [DW-1:0] rd_data_ff;

   // Store a kept box
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_x, wr_y, wr_w, wr_h, wr_cls, wr_area};
      end
   end

   // Read one entry per cycle
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_x    = $signed(rd_data_ff[X_LO +: CB]);
   assign rd_y    = $signed(rd_data_ff[Y_LO +: CB]);
   assign rd_w    = rd_data_ff[W_LO +: WB];
   assign rd_h    = rd_data_ff[H_LO +: WB];
   assign rd_cls  = rd_data_ff[CLS_LO +: CLASS_BITS];
   assign rd_area = rd_data_ff[AREA_LO +: AB];

endmodule

// File: sv/gbs_iou_unit.sv
`timescale 1ns / 1ps
module gbs_iou_unit #(
   parameter int COORD_BITS = gbs_pkg::COORD_BITS,
   localparam int CB = COORD_BITS,
   localparam int WB = COORD_BITS - 1,
   localparam int AB = 2 * (COORD_BITS - 1)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            issue_en,
   input  logic signed [CB-1:0]            cur_x,
   input  logic signed [CB-1:0]            cur_y,
   input  logic [WB-1:0]                   cur_w,
   input  logic [WB-1:0]                   cur_h,
   input  logic [gbs_pkg::CLASS_BITS-1:0]  cur_cls,
   input  logic [AB-1:0]                   cur_area,
   input  logic [gbs_pkg::THR_BITS-1:0]    thr,
   input  logic                            agnostic,
   input  logic signed [CB-1:0]            kept_x,
   input  logic signed [CB-1:0]            kept_y,
   input  logic [WB-1:0]                   kept_w,
   input  logic [WB-1:0]                   kept_h,
   input  logic [gbs_pkg::CLASS_BITS-1:0]  kept_cls,
   input  logic [AB-1:0]                   kept_area,
   output gbs_pkg::unit_status_type        status
);
   import gbs_pkg::*;

   localparam int SB = AB + 1;
   localparam int PW = SB + THR_BITS;

   // Stage 0: valid lines up with the registered store read
   logic s0_valid_ff;

   // Stage 1: overlap extents
   logic signed [CB:0]   cur_x1, cur_y1, kept_x1, kept_y1;
   logic signed [CB-1:0] ix0, iy0;
   logic signed [CB:0]   ix1, iy1;
   logic [CB+1:0]        dx_full, dy_full;
   logic [WB-1:0]        dx_in, dy_in;
   logic                 match_in;
   logic                 s1_valid_ff, s1_match_ff;
   logic [WB-1:0]        s1_dx_ff, s1_dy_ff;
   logic [AB-1:0]        s1_area_ff;

   // Stage 2: intersection and area sum
   logic          s2_valid_ff, s2_match_ff;
   logic [AB-1:0] s2_inter_ff;
   logic [SB-1:0] s2_sum_ff;
   logic [SB-1:0] union_val;

   // Stage 3: both sides of the threshold test
   logic          s3_valid_ff, s3_match_ff;
   logic [PW-1:0] s3_lhs_ff, s3_rhs_ff;

   // Stage 4: result
   logic s4_valid_ff, s4_hit_ff;

   always_comb begin
      cur_x1  = {cur_x[CB-1], cur_x} + $signed({2'b00, cur_w});
      cur_y1  = {cur_y[CB-1], cur_y} + $signed({2'b00, cur_h});
      kept_x1 = {kept_x[CB-1], kept_x} + $signed({2'b00, kept_w});
      kept_y1 = {kept_y[CB-1], kept_y} + $signed({2'b00, kept_h});
      ix0     = (cur_x > kept_x) ? cur_x : kept_x;
      iy0     = (cur_y > kept_y) ? cur_y : kept_y;
      ix1     = (cur_x1 < kept_x1) ? cur_x1 : kept_x1;
      iy1     = (cur_y1 < kept_y1) ? cur_y1 : kept_y1;
      dx_full = {ix1[CB], ix1} - {{2{ix0[CB-1]}}, ix0};
      dy_full = {iy1[CB], iy1} - {{2{iy0[CB-1]}}, iy0};
      // Clamp empty or touching overlap to zero
      dx_in   = (!dx_full[CB+1] && (dx_full != '0)) ? dx_full[WB-1:0] : '0;
      dy_in   = (!dy_full[CB+1] && (dy_full != '0)) ? dy_full[WB-1:0] : '0;
      match_in = agnostic || (kept_cls == cur_cls);
   end

   assign union_val = s2_sum_ff - SB'(s2_inter_ff);

   // Advance the valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s4_hit_ff   <= 1'b0;
      end else begin
         s0_valid_ff <= issue_en;
         s1_valid_ff <= s0_valid_ff;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s4_hit_ff   <= s3_valid_ff && s3_match_ff && (s3_lhs_ff > s3_rhs_ff);
      end
   end

   // Advance the data path
   always_ff @(posedge clock) begin
      s1_match_ff <= match_in;
      s1_dx_ff    <= dx_in;
      s1_dy_ff    <= dy_in;
      s1_area_ff  <= kept_area;

      s2_match_ff <= s1_match_ff;
      s2_inter_ff <= AB'(s1_dx_ff) * AB'(s1_dy_ff);
      s2_sum_ff   <= SB'(cur_area) + SB'(s1_area_ff);

      s3_match_ff <= s2_match_ff;
      s3_lhs_ff   <= PW'({s2_inter_ff, {THR_BITS{1'b0}}});
      s3_rhs_ff   <= PW'(thr) * PW'(union_val);
   end

   assign status.busy = s0_valid_ff | s1_valid_ff | s2_valid_ff | s3_valid_ff | s4_valid_ff;
   assign status.hit  = s4_hit_ff;

endmodule

// File: sv/greedy_box_suppression_top.sv
`timescale 1ns / 1ps
// Greedy non-maximum suppression. Boxes arrive one per transfer in falling
// score order; each is checked against every box already kept in the frame
// (same class only unless class_agnostic is set) and is suppressed when
// intersection * 65536 > iou_threshold * union. A surviving box is stored
// while the kept list has room, otherwise list_full is reported. A box with
// first_of_frame set empties the list and restarts the frame index first.
// Each box passes a setup state for its area, a scan that streams the kept
// list out of the store one entry per cycle into the five-stage overlap
// unit, a drain until that unit is idle (both skipped for an empty list),
// and a finish state that loads the result once the output register is
// free. No new box is taken until the current one has its result loaded
// into the output register, so the next transfer can come in the cycle
// after that load; that register holds a result while the consumer stalls.
module greedy_box_suppression_top #(
   parameter int MAX_KEPT = gbs_pkg::MAX_KEPT_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  gbs_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output gbs_pkg::rsp_type                    rsp_data,
   input  logic                                csr_wr_en,
   input  logic [gbs_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [gbs_pkg::CSR_DATA_BITS-1:0]   csr_wr_data
);
   import gbs_pkg::*;

   localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
   localparam int CW = $clog2(MAX_KEPT + 1);
   localparam int CB = COORD_BITS;
   localparam int WB = COORD_BITS - 1;
   localparam int AB = 2 * (COORD_BITS - 1);

   state_type state_ff, state_in;

   logic [THR_BITS-1:0] thr_ff;
   logic                agnostic_ff;

   logic [CW-1:0]       count_ff, count_in;
   logic [IDX_BITS-1:0] counter_ff, counter_in;
   logic [IDX_BITS-1:0] idx_ff, idx_in, idx_base;
   logic [AW-1:0]       issue_ff, issue_in;
   logic                suppressed_ff, suppressed_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff;

   logic signed [CB-1:0]   cur_x_ff, cur_y_ff;
   logic [WB-1:0]          cur_w_ff, cur_h_ff;
   logic [CLASS_BITS-1:0]  cur_cls_ff;
   logic [AB-1:0]          cur_area_ff;

   logic accept, issue_en, load_rsp, slot_free, last_issue, list_full, store_en;

   logic signed [CB-1:0]  kept_x, kept_y;
   logic [WB-1:0]         kept_w, kept_h;
   logic [CLASS_BITS-1:0] kept_cls;
   logic [AB-1:0]         kept_area;
   unit_status_type       unit_status;

   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign last_issue = (CW'(issue_ff) == (count_ff - CW'(1)));
   assign list_full  = (count_ff == CW'(MAX_KEPT));

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_valid) state_in = S_PREP;
         S_PREP:   state_in = (count_ff == '0) ? S_FINISH : S_SCAN;
         S_SCAN:   if (last_issue) state_in = S_DRAIN;
         S_DRAIN:  if (!unit_status.busy) state_in = S_FINISH;
         S_FINISH: if (slot_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      req_stall = 1'b1;
      accept    = 1'b0;
      issue_en  = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            accept    = req_valid;
         end
         S_SCAN:   issue_en = 1'b1;
         S_FINISH: load_rsp = slot_free;
         default: ;
      endcase
   end

   assign store_en = load_rsp && !suppressed_ff && !list_full;

   // Control next values
   always_comb begin
      idx_base      = req_data.first_of_frame ? '0 : counter_ff;
      count_in      = count_ff;
      counter_in    = counter_ff;
      idx_in        = idx_ff;
      issue_in      = issue_ff;
      suppressed_in = suppressed_ff;
      if (accept) begin
         idx_in     = idx_base;
         counter_in = (idx_base == IDX_MAX) ? idx_base : idx_base + IDX_BITS'(1);
         if (req_data.first_of_frame) begin
            count_in = '0;
         end
      end
      if (state_ff == S_PREP) begin
         issue_in      = '0;
         suppressed_in = 1'b0;
      end
      if (issue_en) begin
         issue_in = issue_ff + AW'(1);
      end
      if (unit_status.hit) begin
         suppressed_in = 1'b1;
      end
      if (store_en) begin
         count_in = count_ff + CW'(1);
      end
      rsp_valid_in = load_rsp || (rsp_valid_ff && rsp_stall);
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         counter_ff    <= '0;
         idx_ff        <= '0;
         issue_ff      <= '0;
         suppressed_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         thr_ff        <= IOU_THRESHOLD_RESET;
         agnostic_ff   <= CLASS_AGNOSTIC_RESET;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         counter_ff    <= counter_in;
         idx_ff        <= idx_in;
         issue_ff      <= issue_in;
         suppressed_ff <= suppressed_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_IOU_THRESHOLD:  thr_ff      <= csr_wr_data[THR_BITS-1:0];
               CSR_CLASS_AGNOSTIC: agnostic_ff <= csr_wr_data[0];
               default: ;
            endcase
         end
      end
   end

   // Capture the box and its area; load the result
   always_ff @(posedge clock) begin
      if (accept) begin
         cur_x_ff   <= CB'(req_data.box_x);
         cur_y_ff   <= CB'(req_data.box_y);
         cur_w_ff   <= WB'(req_data.box_w);
         cur_h_ff   <= WB'(req_data.box_h);
         cur_cls_ff <= req_data.class_label;
      end
      if (state_ff == S_PREP) begin
         cur_area_ff <= AB'(cur_w_ff) * AB'(cur_h_ff);
      end
      if (load_rsp) begin
         rsp_data_ff.keep        <= !suppressed_ff && !list_full;
         rsp_data_ff.input_index <= idx_ff;
         rsp_data_ff.list_full   <= !suppressed_ff && list_full;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   gbs_store #(
      .MAX_KEPT   (MAX_KEPT),
      .COORD_BITS (COORD_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_x    (cur_x_ff),
      .wr_y    (cur_y_ff),
      .wr_w    (cur_w_ff),
      .wr_h    (cur_h_ff),
      .wr_cls  (cur_cls_ff),
      .wr_area (cur_area_ff),
      .rd_addr (issue_ff),
      .rd_x    (kept_x),
      .rd_y    (kept_y),
      .rd_w    (kept_w),
      .rd_h    (kept_h),
      .rd_cls  (kept_cls),
      .rd_area (kept_area)
   );

   gbs_iou_unit #(
      .COORD_BITS (COORD_BITS)
   ) u_iou_unit (
      .clock     (clock),
      .reset     (reset),
      .issue_en  (issue_en),
      .cur_x     (cur_x_ff),
      .cur_y     (cur_y_ff),
      .cur_w     (cur_w_ff),
      .cur_h     (cur_h_ff),
      .cur_cls   (cur_cls_ff),
      .cur_area  (cur_area_ff),
      .thr       (thr_ff),
      .agnostic  (agnostic_ff),
      .kept_x    (kept_x),
      .kept_y    (kept_y),
      .kept_w    (kept_w),
      .kept_h    (kept_h),
      .kept_cls  (kept_cls),
      .kept_area (kept_area),
      .status    (unit_status)
   );

endmodule

// File: dv/box_suppression_check.sv
`timescale 1ns / 1ps
module box_suppression_check (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  gbs_pkg::req_type                    req_data,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  gbs_pkg::rsp_type                    rsp_data,
   input  logic                                csr_wr_en,
   input  logic [gbs_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [gbs_pkg::CSR_DATA_BITS-1:0]   csr_wr_data,
   output int                                  mismatch_count,
   output int                                  verdicts_pending
);
   import gbs_pkg::*;

   localparam int KEPT_SLOTS  = MAX_KEPT_DEFAULT;
   localparam int MAX_REPORTS = 10;

   // Shadow copy of the kept list and the frame position
   longint                 kept_x    [KEPT_SLOTS];
   longint                 kept_y    [KEPT_SLOTS];
   longint                 kept_w    [KEPT_SLOTS];
   longint                 kept_h    [KEPT_SLOTS];
   longint unsigned        kept_area [KEPT_SLOTS];
   logic [CLASS_BITS-1:0]  kept_cls  [KEPT_SLOTS];
   int                     kept_total = 0;
   int                     frame_pos  = 0;

   // Shadow copy of the registers
   logic [THR_BITS-1:0]    overlap_limit = IOU_THRESHOLD_RESET;
   logic                   all_classes   = CLASS_AGNOSTIC_RESET;

   rsp_type                expected_verdicts [$];
   int                     queue_depth = 0;
   int                     failures = 0;

   assign mismatch_count   = failures;
   assign verdicts_pending = queue_depth;

   // Decide keep / suppress / full for one box and update the kept list
   function automatic rsp_type judge_box(input req_type b);
      longint          cx, cy, cw, ch;
      longint          lo_x, lo_y, hi_x, hi_y;
      longint unsigned box_area, inter, uni;
      bit              hit;
      rsp_type         r;
      hit = 1'b0;
      if (b.first_of_frame) begin
         kept_total = 0;
         frame_pos  = 0;
      end
      cx = longint'($signed(b.box_x));
      cy = longint'($signed(b.box_y));
      cw = longint'(b.box_w);
      ch = longint'(b.box_h);
      box_area = longint'(cw * ch);
      r.input_index = frame_pos[IDX_BITS-1:0];
      if (frame_pos < 65535)
         frame_pos++;
      for (int j = 0; j < kept_total; j++) begin
         if (!all_classes && kept_cls[j] != b.class_label)
            continue;
         lo_x = (cx > kept_x[j]) ? cx : kept_x[j];
         lo_y = (cy > kept_y[j]) ? cy : kept_y[j];
         hi_x = (cx + cw < kept_x[j] + kept_w[j]) ? cx + cw : kept_x[j] + kept_w[j];
         hi_y = (cy + ch < kept_y[j] + kept_h[j]) ? cy + ch : kept_y[j] + kept_h[j];
         if (hi_x > lo_x && hi_y > lo_y)
            inter = longint'((hi_x - lo_x) * (hi_y - lo_y));
         else
            inter = 0;
         uni = box_area + kept_area[j] - inter;
         if (uni > 0 && (inter << 16) > longint'(overlap_limit) * uni)
            hit = 1'b1;
      end
      r.keep      = 1'b0;
      r.list_full = 1'b0;
      if (!hit) begin
         if (kept_total < KEPT_SLOTS) begin
            kept_x[kept_total]    = cx;
            kept_y[kept_total]    = cy;
            kept_w[kept_total]    = cw;
            kept_h[kept_total]    = ch;
            kept_area[kept_total] = box_area;
            kept_cls[kept_total]  = b.class_label;
            kept_total++;
            r.keep = 1'b1;
         end else begin
            r.list_full = 1'b1;
         end
      end
      return r;
   endfunction

   function automatic void note_failure(input string msg);
      failures++;
      if (failures <= MAX_REPORTS)
         $display("%s", msg);
   endfunction

   // Track register writes, predict on each box transfer, compare on each result
   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         overlap_limit = IOU_THRESHOLD_RESET;
         all_classes   = CLASS_AGNOSTIC_RESET;
         kept_total    = 0;
         frame_pos     = 0;
         expected_verdicts.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_IOU_THRESHOLD:  overlap_limit = csr_wr_data[THR_BITS-1:0];
               CSR_CLASS_AGNOSTIC: all_classes   = csr_wr_data[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            expected_verdicts = {expected_verdicts, judge_box(req_data)};
         if (rsp_valid && !rsp_stall) begin
            if (expected_verdicts.size() == 0) begin
               note_failure($sformatf("%0t: result with none expected: keep=%0d index=%0d full=%0d",
                  $realtime, rsp_data.keep, rsp_data.input_index, rsp_data.list_full));
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_data.keep !== want.keep || rsp_data.input_index !== want.input_index ||
                   rsp_data.list_full !== want.list_full)
                  note_failure($sformatf(
                     "%0t: expected keep=%0d index=%0d full=%0d, got keep=%0d index=%0d full=%0d",
                     $realtime, want.keep, want.input_index, want.list_full,
                     rsp_data.keep, rsp_data.input_index, rsp_data.list_full));
            end
         end
      end
      queue_depth = expected_verdicts.size();
   end

endmodule

// File: dv/tb_greedy_box_suppression_top.sv
`timescale 1ns / 1ps
module tb_greedy_box_suppression_top;
   import gbs_pkg::*;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   req_type                    req_data;
   logic                       rsp_valid;
   logic                       rsp_stall;
   rsp_type                    rsp_data;
   logic                       csr_wr_en;
   logic [CSR_INDEX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0]   csr_wr_data;
   int                         mismatch_count;
   int                         verdicts_pending;

   int                         sender_max_gap   = 18;
   int                         receiver_max_gap = 18;
   int                         hold_cycles      = 0;
   req_type                    recent_boxes [$];

   greedy_box_suppression_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   box_suppression_check verdict_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data),
      .mismatch_count   (mismatch_count),
      .verdicts_pending (verdicts_pending)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic req_type make_box(input int x, input int y, input int w, input int h,
                                        input int cls, input bit first);
      req_type b;
      b.box_x          = 16'(x);
      b.box_y          = 16'(y);
      b.box_w          = 15'(w);
      b.box_h          = 15'(h);
      b.class_label    = 8'(cls);
      b.first_of_frame = first;
      return b;
   endfunction

   // Draw a box: mostly near earlier boxes of the frame, some fresh, a few raw noise
   function automatic req_type random_box(input bit first);
      int      roll, tw, th;
      req_type b;
      req_type base;
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
         b.box_x          = 16'($urandom);
         b.box_y          = 16'($urandom);
         b.box_w          = 15'($urandom);
         b.box_h          = 15'($urandom);
         b.class_label    = 8'($urandom);
         b.first_of_frame = first | ($urandom_range(0, 7) == 0);
      end else if (roll < 60 && recent_boxes.size() > 0) begin
         base = recent_boxes[$urandom_range(0, recent_boxes.size() - 1)];
         tw   = int'(base.box_w) + int'($urandom_range(0, 64)) - 32;
         th   = int'(base.box_h) + int'($urandom_range(0, 64)) - 32;
         b.box_x          = base.box_x + 16'(int'($urandom_range(0, 64)) - 32);
         b.box_y          = base.box_y + 16'(int'($urandom_range(0, 64)) - 32);
         b.box_w          = 15'((tw < 0) ? 0 : (tw > 32767) ? 32767 : tw);
         b.box_h          = 15'((th < 0) ? 0 : (th > 32767) ? 32767 : th);
         b.class_label    = ($urandom_range(0, 6) == 0) ? 8'($urandom) : base.class_label;
         b.first_of_frame = first;
      end else if ($urandom_range(0, 9) == 0) begin
         b.box_x          = 16'($urandom);
         b.box_y          = 16'($urandom);
         b.box_w          = 15'($urandom_range(0, 32767));
         b.box_h          = 15'($urandom_range(0, 32767));
         b.class_label    = 8'($urandom_range(0, 3));
         b.first_of_frame = first;
      end else begin
         b = make_box(int'($urandom_range(0, 8191)) - 4096, int'($urandom_range(0, 8191)) - 4096,
                      $urandom_range(16, 1024), $urandom_range(16, 1024),
                      $urandom_range(0, 3), first);
      end
      if (b.first_of_frame)
         recent_boxes.delete();
      recent_boxes = {recent_boxes, b};
      if (recent_boxes.size() > 24)
         void'(recent_boxes.pop_front());
      return b;
   endfunction

   // Offer one box after a random gap and hold it until the transfer
   task automatic offer_box(input req_type b);
      int gap;
      gap = (sender_max_gap == 0) ? 0 : $urandom_range(0, sender_max_gap);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data  = b;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Drop valid and wait until every expected result is back, then a tail
   task automatic wait_idle(input int tail);
      int spins;
      spins     = 0;
      req_valid = 1'b0;
      while (verdicts_pending != 0 && spins < 50000) begin
         @(negedge clock);
         spins++;
      end
      repeat (tail) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_index   = idx;
      csr_wr_data = value;
      csr_wr_en   = 1'b1;
      @(negedge clock);
      csr_wr_en   = 1'b0;
   endtask

   // Result side: random stall per result, plus a long hold-off on request
   initial begin : result_side
      int n;
      rsp_stall = 1'b0;
      forever begin
         if (hold_cycles > 0) begin
            rsp_stall = 1'b1;
            repeat (hold_cycles) @(negedge clock);
            hold_cycles = 0;
         end
         n = (receiver_max_gap == 0) ? 0 : $urandom_range(0, receiver_max_gap);
         if (n > 0) begin
            rsp_stall = 1'b1;
            repeat (n) @(negedge clock);
         end
         rsp_stall = 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   initial begin : time_limit
      #20000000;
      $display("tb_greedy_box_suppression_top: FAIL");
      $finish;
   end

   initial begin : stimulus
      int  frame_left;
      int  thr;
      bit  first;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_wr_en   = 1'b0;
      csr_index   = '0;
      csr_wr_data = '0;
      frame_left  = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Default threshold, per-class compare
      write_reg(CSR_IOU_THRESHOLD, IOU_THRESHOLD_RESET);
      write_reg(CSR_CLASS_AGNOSTIC, 1'b0);
      offer_box(make_box(0, 0, 160, 160, 1, 1));
      offer_box(make_box(8, 8, 160, 160, 1, 0));                  // heavy overlap
      offer_box(make_box(160, 0, 160, 160, 1, 0));                // touching edge
      offer_box(make_box(0, 0, 160, 160, 2, 0));                  // other class
      offer_box(make_box(-32768, -32768, 32767, 32767, 7, 0));
      offer_box(make_box(32767, 32767, 32767, 32767, 7, 0));      // edge sum past 16 bits
      offer_box(make_box(32767, 32767, 32767, 32767, 7, 0));
      offer_box(make_box(100, 100, 0, 0, 9, 0));                  // empty boxes
      offer_box(make_box(100, 100, 0, 0, 9, 0));
      offer_box(make_box(-1, -1, 32767, 32767, 255, 1));

      // Zero threshold: any overlap suppresses
      wait_idle(20);
      write_reg(CSR_IOU_THRESHOLD, 16'd0);
      offer_box(make_box(0, 0, 32, 32, 3, 1));
      offer_box(make_box(31, 31, 32, 32, 3, 0));
      offer_box(make_box(32, 0, 32, 32, 3, 0));

      // Top threshold: only identical boxes suppress
      wait_idle(20);
      write_reg(CSR_IOU_THRESHOLD, 16'hFFFF);
      offer_box(make_box(0, 0, 4096, 4096, 4, 1));
      offer_box(make_box(1, 0, 4096, 4096, 4, 0));
      offer_box(make_box(0, 0, 4096, 4096, 4, 0));

      // Compare across classes
      wait_idle(20);
      write_reg(CSR_IOU_THRESHOLD, IOU_THRESHOLD_RESET);
      write_reg(CSR_CLASS_AGNOSTIC, 1'b1);
      offer_box(make_box(0, 0, 64, 64, 5, 1));
      offer_box(make_box(4, 4, 64, 64, 6, 0));

      // Fill the kept list with empty boxes, then overflow and suppress
      offer_box(make_box(0, 0, 320, 320, 0, 1));
      for (int i = 1; i < 132; i++)
         offer_box(make_box(i * 16, 0, 0, 160, i, 0));
      offer_box(make_box(0, 0, 320, 320, 0, 0));

      // Long result hold-off while the sender keeps pushing
      wait_idle(20);
      sender_max_gap   = 0;
      receiver_max_gap = 0;
      hold_cycles      = 400;
      for (int i = 0; i < 20; i++)
         offer_box(random_box(i == 0));

      // Random phases over several register settings and idle patterns
      for (int phase = 0; phase < 8; phase++) begin
         wait_idle(20);
         case (phase)
            0: thr = 0;
            1: thr = 65535;
            default: begin
               case ($urandom_range(0, 3))
                  0: thr = 0;
                  1: thr = 65535;
                  2: thr = IOU_THRESHOLD_RESET;
                  default: thr = $urandom_range(0, 65535);
               endcase
            end
         endcase
         write_reg(CSR_IOU_THRESHOLD, 16'(thr));
         write_reg(CSR_CLASS_AGNOSTIC, (phase % 2 == 1) ? 1'b1 : 1'($urandom_range(0, 1)));
         sender_max_gap   = (phase % 3 == 1) ? 0 : 18;
         receiver_max_gap = (phase % 4 == 2) ? 0 : 18;
         for (int n = 0; n < 210; n++) begin
            first = (frame_left == 0);
            if (first)
               frame_left = ($urandom_range(0, 19) == 0) ? $urandom_range(130, 170)
                                                         : $urandom_range(1, 30);
            offer_box(random_box(first));
            frame_left--;
         end
      end

      wait_idle(200);
      if (mismatch_count == 0 && verdicts_pending == 0)
         $display("tb_greedy_box_suppression_top: PASS");
      else
         $display("tb_greedy_box_suppression_top: FAIL");
      $finish;
   end

endmodule

// File: sim.f
sv/gbs_pkg.sv
sv/gbs_store.sv
sv/gbs_iou_unit.sv
sv/greedy_box_suppression_top.sv
dv/box_suppression_check.sv
dv/tb_greedy_box_suppression_top.sv
